### sv/mqcp_pkg.sv
// Shared types and constants for the multi-queue context pool.
// Holds the controller state type, request and status codes, and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mqcp_pkg;

    // Default pool geometry.
    localparam int NUM_CONTEXTS_DEF = 16;
    localparam int NUM_STATES_DEF   = 16;

    // Fixed field widths of the stream payload.
    localparam int FIELD_W = 4;
    localparam int STS_W   = 2;

    // Request kinds carried in tuser.
    typedef enum logic {
        OP_TAKE = 1'b0,
        OP_MOVE = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [STS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_STATE = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_BAD_INDEX = 2'd3
    } t_status;

    // Controller phases.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOOKUP,
        ST_UNLINK,
        ST_TAIL_RD,
        ST_LINK,
        ST_TERM,
        ST_FINISH
    } t_state;

    // Strobes from controller to datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic lookup;
        logic unlink;
        logic link;
        logic term;
        logic out_load;
    } t_dp_cmd;

    // Conditions reported by the datapath.
    typedef struct packed {
        logic reject;
        logic empty;
    } t_dp_stat;

endpackage

### sv/mqcp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for every link, state, head and tail table. No dependencies.
`timescale 1ns / 1ps

module mqcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mqcp_ctrl.sv
// Controller for the multi-queue context pool: sequences each request
// through check, lookup, unlink and link phases and owns the stream handshakes.
// Depends on mqcp_pkg.
`timescale 1ns / 1ps

module mqcp_ctrl
    import mqcp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    output logic     o_m_axis_tvalid,
    input  logic     i_m_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign accept = i_s_axis_tvalid && (r_state == ST_IDLE);

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath strobes.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.reject ? ST_FINISH : ST_LOOKUP;
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_stat.empty ? ST_FINISH : ST_UNLINK;
            end
            ST_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state      = ST_TAIL_RD;
            end
            ST_TAIL_RD: begin
                n_state = ST_LINK;
            end
            ST_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = ST_TERM;
            end
            ST_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = ST_FINISH;
            end
            ST_FINISH: begin
                // The result register takes the new transaction once it is free.
                if (!r_out_valid || i_m_axis_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

`ifndef NO_ASSERTIONS
    // An accepted request always starts with the check phase.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == ST_CHECK))
        else $error("accepted request did not enter the check phase");

    // A rejected request goes straight to the result phase.
    a_reject_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && i_stat.reject) |=> (r_state == ST_FINISH))
        else $error("rejected request touched the link tables");

    // Linking is only reached through the tail read.
    a_link_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LINK) |-> ($past(r_state) == ST_TAIL_RD))
        else $error("link phase entered out of order");

    // No new request is taken while one is still in progress.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_s_axis_tready)
        else $error("input ready while a request is in progress");
`endif

endmodule

### sv/mqcp_dpath.sv
// Datapath for the multi-queue context pool: request and result registers,
// the link, state, head and tail tables with their reset-valid bits.
// Depends on mqcp_pkg and mqcp_ram.
`timescale 1ns / 1ps

module mqcp_dpath
    import mqcp_pkg::*;
#(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
    parameter int NUM_STATES   = NUM_STATES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_dp_cmd      i_cmd,
    output t_dp_stat     o_stat,
    input  logic         i_op,
    input  logic [15:0]  i_req,
    output logic [15:0]  o_rsp
);

    localparam int IW  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int LW  = $clog2(NUM_CONTEXTS + 1);
    localparam int SAW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam logic [LW-1:0] NUL = LW'(NUM_CONTEXTS);

    // Reset contents of the tables, used while an entry is still unwritten.
    function automatic logic [LW-1:0] nx_rst(input logic [IW-1:0] a);
        return LW'(a) + LW'(1);
    endfunction

    function automatic logic [LW-1:0] pv_rst(input logic [IW-1:0] a);
        return (a == '0) ? NUL : (LW'(a) - LW'(1));
    endfunction

    function automatic logic [LW-1:0] hd_rst(input logic [SAW-1:0] s);
        return (s == '0) ? '0 : NUL;
    endfunction

    function automatic logic [LW-1:0] tl_rst(input logic [SAW-1:0] s);
        return (s == '0) ? LW'(NUM_CONTEXTS - 1) : NUL;
    endfunction

    // Request fields and working registers.
    t_op                r_op;
    logic [FIELD_W-1:0] r_src, r_dst, r_idx;
    logic [IW-1:0]      r_ctx;
    logic [SAW-1:0]     r_qs;
    t_status            r_status;
    logic [15:0]        r_rsp;

    // Table ports.
    logic           nx_we, pv_we, hd_we, tl_we, cs_we;
    logic [IW-1:0]  nx_waddr, pv_waddr, cs_waddr, nx_raddr, cs_raddr;
    logic [SAW-1:0] hd_waddr, tl_waddr, hd_raddr, tl_raddr;
    logic [LW-1:0]  nx_wdata, pv_wdata, hd_wdata, tl_wdata;
    logic [SAW-1:0] cs_wdata;
    logic [LW-1:0]  nx_q, pv_q, hd_q, tl_q;
    logic [SAW-1:0] cs_q;

    // Written-entry flags and sampled read addresses.
    logic [NUM_CONTEXTS-1:0] r_nx_vld, r_pv_vld, r_cs_vld;
    logic [NUM_STATES-1:0]   r_hd_vld, r_tl_vld;
    logic                    r_nx_rv, r_pv_rv, r_cs_rv, r_hd_rv, r_tl_rv;
    logic [IW-1:0]           r_nx_ra, r_pv_ra;
    logic [SAW-1:0]          r_hd_ra, r_tl_ra;

    // Resolved read data.
    logic [LW-1:0]  nx_data, pv_data, hd_data, tl_data;
    logic [SAW-1:0] cs_data;
    logic           p_valid, n_valid, t_valid;
    logic [IW-1:0]  c_cur;
    t_status        chk_code;

    assign nx_data = r_nx_rv ? nx_q : nx_rst(r_nx_ra);
    assign pv_data = r_pv_rv ? pv_q : pv_rst(r_pv_ra);
    assign hd_data = r_hd_rv ? hd_q : hd_rst(r_hd_ra);
    assign tl_data = r_tl_rv ? tl_q : tl_rst(r_tl_ra);
    assign cs_data = r_cs_rv ? cs_q : '0;

    assign p_valid = (pv_data != NUL);
    assign n_valid = (nx_data != NUL);
    assign t_valid = (tl_data != NUL);

    // Range checks on the request.
    always_comb begin
        chk_code = STS_OK;
        if ({4'b0, r_dst} >= 8'(NUM_STATES)) begin
            chk_code = STS_BAD_STATE;
        end else if (r_op == OP_TAKE) begin
            if ({4'b0, r_src} >= 8'(NUM_STATES)) begin
                chk_code = STS_BAD_STATE;
            end
        end else if ({5'b0, r_idx} >= 9'(NUM_CONTEXTS)) begin
            chk_code = STS_BAD_INDEX;
        end
    end

    assign o_stat.reject = (chk_code != STS_OK);
    assign o_stat.empty  = (r_op == OP_TAKE) && (hd_data == NUL);

    // Context under work: head of the source queue or the named one.
    assign c_cur = (r_op == OP_TAKE) ? IW'(hd_data) : IW'(r_idx);

    // Read addresses.
    assign hd_raddr = SAW'(r_src);
    assign cs_raddr = IW'(r_idx);
    assign nx_raddr = c_cur;
    assign tl_raddr = SAW'(r_dst);

    // Write ports: unlink splices around the context, link appends it,
    // and the final step terminates its forward link.
    always_comb begin
        nx_we    = (i_cmd.unlink && p_valid) || (i_cmd.link && t_valid) || i_cmd.term;
        nx_waddr = i_cmd.unlink ? IW'(pv_data) : (i_cmd.link ? IW'(tl_data) : r_ctx);
        nx_wdata = i_cmd.unlink ? nx_data : (i_cmd.link ? LW'(r_ctx) : NUL);

        pv_we    = (i_cmd.unlink && n_valid) || i_cmd.link;
        pv_waddr = i_cmd.unlink ? IW'(nx_data) : r_ctx;
        pv_wdata = i_cmd.unlink ? pv_data : tl_data;

        hd_we    = (i_cmd.unlink && !p_valid) || (i_cmd.link && !t_valid);
        hd_waddr = i_cmd.unlink ? r_qs : SAW'(r_dst);
        hd_wdata = i_cmd.unlink ? nx_data : LW'(r_ctx);

        tl_we    = (i_cmd.unlink && !n_valid) || i_cmd.link;
        tl_waddr = i_cmd.unlink ? r_qs : SAW'(r_dst);
        tl_wdata = i_cmd.unlink ? pv_data : LW'(r_ctx);

        cs_we    = i_cmd.link;
        cs_waddr = r_ctx;
        cs_wdata = SAW'(r_dst);
    end

    // Written-entry flags, cleared by reset, and sampled read state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx_vld <= '0;
            r_pv_vld <= '0;
            r_cs_vld <= '0;
            r_hd_vld <= '0;
            r_tl_vld <= '0;
            r_nx_rv  <= 1'b0;
            r_pv_rv  <= 1'b0;
            r_cs_rv  <= 1'b0;
            r_hd_rv  <= 1'b0;
            r_tl_rv  <= 1'b0;
        end else begin
            if (nx_we) r_nx_vld[nx_waddr] <= 1'b1;
            if (pv_we) r_pv_vld[pv_waddr] <= 1'b1;
            if (cs_we) r_cs_vld[cs_waddr] <= 1'b1;
            if (hd_we) r_hd_vld[hd_waddr] <= 1'b1;
            if (tl_we) r_tl_vld[tl_waddr] <= 1'b1;
            r_nx_rv <= r_nx_vld[nx_raddr];
            r_pv_rv <= r_pv_vld[nx_raddr];
            r_cs_rv <= r_cs_vld[cs_raddr];
            r_hd_rv <= r_hd_vld[hd_raddr];
            r_tl_rv <= r_tl_vld[tl_raddr];
        end
    end

    // Request, working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_nx_ra <= nx_raddr;
        r_pv_ra <= nx_raddr;
        r_hd_ra <= hd_raddr;
        r_tl_ra <= tl_raddr;
        if (i_cmd.load) begin
            r_op  <= t_op'(i_op);
            r_src <= i_req[3:0];
            r_dst <= i_req[7:4];
            r_idx <= i_req[11:8];
        end
        if (i_cmd.check) begin
            r_status <= chk_code;
        end
        if (i_cmd.lookup) begin
            r_ctx <= c_cur;
            r_qs  <= (r_op == OP_TAKE) ? SAW'(r_src) : cs_data;
            if (o_stat.empty) begin
                r_status <= STS_EMPTY;
            end
        end
        if (i_cmd.out_load) begin
            r_rsp <= (r_status == STS_OK)
                   ? {6'b0, FIELD_W'(r_qs), FIELD_W'(r_ctx), r_status}
                   : {6'b0, {FIELD_W{1'b0}}, {FIELD_W{1'b0}}, r_status};
        end
    end

    assign o_rsp = r_rsp;

    mqcp_ram #(.WIDTH(LW), .DEPTH(NUM_CONTEXTS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(nx_raddr), .o_rdata(nx_q)
    );

    mqcp_ram #(.WIDTH(LW), .DEPTH(NUM_CONTEXTS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(nx_raddr), .o_rdata(pv_q)
    );

    mqcp_ram #(.WIDTH(SAW), .DEPTH(NUM_CONTEXTS)) u_ctx_state (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(cs_wdata),
        .i_raddr(cs_raddr), .o_rdata(cs_q)
    );

    mqcp_ram #(.WIDTH(LW), .DEPTH(NUM_STATES)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(hd_q)
    );

    mqcp_ram #(.WIDTH(LW), .DEPTH(NUM_STATES)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_waddr), .i_wdata(tl_wdata),
        .i_raddr(tl_raddr), .o_rdata(tl_q)
    );

`ifndef NO_ASSERTIONS
    // A context taken from a queue head has no predecessor.
    a_head_no_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.unlink && r_op == OP_TAKE) |-> !p_valid)
        else $error("queue head has a predecessor link");

    // Neighbors of an unlinked context are distinct.
    a_distinct_nbrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.unlink && p_valid && n_valid) |-> (pv_data != nx_data))
        else $error("context has the same predecessor and successor");

    // After unlinking, the destination tail is never the context itself.
    a_tail_not_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.link |-> (tl_data != LW'(r_ctx)))
        else $error("context appended after itself");
`endif

endmodule

### sv/multi_queue_context_pool.sv
// Multi-queue context pool: fixed pool of contexts kept in per-state
// FIFO queues. Top level joining controller and datapath.
// Depends on mqcp_pkg, mqcp_ctrl, mqcp_dpath and mqcp_ram.
//
// Usage: one request transaction on the slave stream gives exactly one
// result transaction on the master stream. tuser carries the request kind
// (take the head of a source queue, or move a named context); tdata carries
// the source state, destination state and context index. The result gives
// a status code, the context taken or moved and the state it held before.
// A relinking request passes the check, lookup, unlink, tail read, link and
// term phases before its result is registered; one with states or index out
// of range goes from check to the result phase, one with an empty source
// queue from lookup. One request is handled at a time, so a new request is
// taken in the cycle after the result is registered. The chain of dependent
// registered reads and writes to the link, head and tail tables sets the pace.
// After reset every context sits in the free queue (state 0) in index order.
// A stalled receiver holds the result in the output register; the block
// still takes one more request and holds it finished until the register frees.
`timescale 1ns / 1ps

module multi_queue_context_pool
    import mqcp_pkg::*;
#(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
    parameter int NUM_STATES   = NUM_STATES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // src_state[3:0], dst_state[7:4],
                                         // context_index[11:8], zero [15:12]
    input  logic        i_s_axis_tuser,  // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // status[1:0], result_index[5:2],
                                         // previous_state[9:6], zero [15:10]
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mqcp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    mqcp_dpath #(
        .NUM_CONTEXTS (NUM_CONTEXTS),
        .NUM_STATES   (NUM_STATES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_op    (i_s_axis_tuser),
        .i_req   (i_s_axis_tdata),
        .o_rsp   (o_m_axis_tdata)
    );

endmodule
